>>> design/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg: shared types and constants for the modular exponentiation block
// Holds the sequencer state type and the fixed operand width.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int DATA_BITS = 64;
    localparam int CNT_W     = $clog2(DATA_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_BASE,
        ST_RED_EXP,
        ST_EXP_BIT,
        ST_MUL,
        ST_DONE
    } state_t;

endpackage

>>> design/mexp_mod_unit.sv
// ----------------------------------------------------------------------------
// mexp_mod_unit: shared modular add and double unit
// Gives (a + b) mod m when add_en is set (else a), and (2b + cin) mod m.
// Both operands must be below m. One compare and subtract per lane.
// ----------------------------------------------------------------------------
module mexp_mod_unit #(
    parameter int W = 64
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] m,
    input  logic         add_en,
    input  logic         cin,
    output logic [W-1:0] sum_mod,
    output logic [W-1:0] dbl_mod
);

    logic [W:0] sum_raw;
    logic [W:0] sum_red;
    logic [W:0] dbl_raw;
    logic [W:0] dbl_red;
    logic [W:0] m_ext;

    assign m_ext   = {1'b0, m};
    assign sum_raw = {1'b0, a} + {1'b0, b};
    assign sum_red = (sum_raw >= m_ext) ? (sum_raw - m_ext) : sum_raw;
    assign dbl_raw = {b, cin};
    assign dbl_red = (dbl_raw >= m_ext) ? (dbl_raw - m_ext) : dbl_raw;

    assign sum_mod = add_en ? sum_red[W-1:0] : a;
    assign dbl_mod = dbl_red[W-1:0];

endmodule

>>> design/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation: base^exponent mod modulus, square and multiply
// Input channel (in_valid/in_stall) carries cmd, base, exponent, modulus and
// expected; a beat is taken when in_valid is high and in_stall low. The
// output channel (out_valid/out_stall) returns power, match and bad_modulus,
// one beat per input beat, held stable while out_stall is high.
// One item at a time: in_stall stays high from the accepted beat until the
// result is loaded into the output register. Work per item, in order:
//   base and expected are reduced mod m one bit per cycle (ST_RED_BASE,
//   ST_RED_EXP); then per exponent bit below the top set bit: one square,
//   and one product before it when the bit is set; the top set bit takes
//   one product. Each product or square steps through the multiplier bits
//   up to its top set bit, one add/double per bit.
// All of it runs through the single shared modular add/double unit. A zero
// modulus skips the work and returns power 0 with bad_modulus set.
// A finished result waits in ST_DONE while the output register holds an
// unaccepted beat. Reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int MOD_BITS = 64,
    parameter int EXP_BITS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           cmd,
    input  logic [mexp_pkg::DATA_BITS-1:0] base,
    input  logic [mexp_pkg::DATA_BITS-1:0] exponent,
    input  logic [mexp_pkg::DATA_BITS-1:0] modulus,
    input  logic [mexp_pkg::DATA_BITS-1:0] expected,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mexp_pkg::DATA_BITS-1:0] power,
    output logic                           match,
    output logic                           bad_modulus
);

    import mexp_pkg::*;

    state_t                state_reg, state_next;
    logic [MOD_BITS-1:0]   m_reg, m_next;
    logic [EXP_BITS-1:0]   e_reg, e_next;
    logic                  cmd_reg, cmd_next;
    logic                  bad_reg, bad_next;
    logic [DATA_BITS-1:0]  src_reg, src_next;
    logic [DATA_BITS-1:0]  xsrc_reg, xsrc_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [MOD_BITS-1:0]   x_reg, x_next;
    logic [MOD_BITS-1:0]   y_reg, y_next;
    logic [MOD_BITS-1:0]   p_reg, p_next;
    logic [MOD_BITS-1:0]   acc_reg, acc_next;
    logic [MOD_BITS-1:0]   sq_reg, sq_next;
    logic [MOD_BITS-1:0]   exp_reg, exp_next;
    logic                  is_sq_reg, is_sq_next;
    logic                  ov_reg, ov_next;
    logic [DATA_BITS-1:0]  power_reg, power_next;
    logic                  match_reg, match_next;
    logic                  badout_reg, badout_next;

    logic [MOD_BITS-1:0]   u_a;
    logic                  u_add_en;
    logic                  u_cin;
    logic [MOD_BITS-1:0]   u_sum;
    logic [MOD_BITS-1:0]   u_dbl;

    mexp_mod_unit #(
        .W (MOD_BITS)
    ) u_mod (
        .a       (u_a),
        .b       (x_reg),
        .m       (m_reg),
        .add_en  (u_add_en),
        .cin     (u_cin),
        .sum_mod (u_sum),
        .dbl_mod (u_dbl)
    );

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = ov_reg;
    assign power       = power_reg;
    assign match       = match_reg;
    assign bad_modulus = badout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        e_reg      <= e_next;
        cmd_reg    <= cmd_next;
        bad_reg    <= bad_next;
        src_reg    <= src_next;
        xsrc_reg   <= xsrc_next;
        cnt_reg    <= cnt_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        p_reg      <= p_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        exp_reg    <= exp_next;
        is_sq_reg  <= is_sq_next;
        power_reg  <= power_next;
        match_reg  <= match_next;
        badout_reg <= badout_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        m_next      = m_reg;
        e_next      = e_reg;
        cmd_next    = cmd_reg;
        bad_next    = bad_reg;
        src_next    = src_reg;
        xsrc_next   = xsrc_reg;
        cnt_next    = cnt_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        p_next      = p_reg;
        acc_next    = acc_reg;
        sq_next     = sq_reg;
        exp_next    = exp_reg;
        is_sq_next  = is_sq_reg;
        power_next  = power_reg;
        match_next  = match_reg;
        badout_next = badout_reg;
        ov_next     = ov_reg && out_stall;
        u_a         = p_reg;
        u_add_en    = 1'b0;
        u_cin       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    m_next    = modulus[MOD_BITS-1:0];
                    e_next    = exponent[EXP_BITS-1:0];
                    cmd_next  = cmd;
                    src_next  = base;
                    xsrc_next = expected;
                    x_next    = '0;
                    cnt_next  = CNT_W'(DATA_BITS - 1);
                    bad_next  = (modulus[MOD_BITS-1:0] == '0);
                    state_next = (modulus[MOD_BITS-1:0] == '0) ? ST_DONE : ST_RED_BASE;
                end
            end
            ST_RED_BASE:
            begin
                u_cin    = src_reg[DATA_BITS-1];
                src_next = src_reg << 1;
                x_next   = u_dbl;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    sq_next    = u_dbl;
                    src_next   = xsrc_reg;
                    x_next     = '0;
                    cnt_next   = CNT_W'(DATA_BITS - 1);
                    state_next = ST_RED_EXP;
                end
            end
            ST_RED_EXP:
            begin
                u_cin    = src_reg[DATA_BITS-1];
                src_next = src_reg << 1;
                x_next   = u_dbl;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    exp_next   = u_dbl;
                    acc_next   = (m_reg == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
                    state_next = ST_EXP_BIT;
                end
            end
            ST_EXP_BIT:
            begin
                p_next = '0;
                x_next = sq_reg;
                if (e_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else if (e_reg[0])
                begin
                    y_next     = acc_reg;
                    is_sq_next = 1'b0;
                    state_next = ST_MUL;
                end
                else
                begin
                    y_next     = sq_reg;
                    is_sq_next = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (y_reg == '0)
                begin
                    if (is_sq_reg)
                    begin
                        sq_next = p_reg;
                        e_next  = e_reg >> 1;
                    end
                    else
                    begin
                        acc_next = p_reg;
                        e_next   = {e_reg[EXP_BITS-1:1], 1'b0};
                    end
                    state_next = ST_EXP_BIT;
                end
                else
                begin
                    u_add_en = y_reg[0];
                    p_next   = u_sum;
                    x_next   = u_dbl;
                    y_next   = y_reg >> 1;
                end
            end
            ST_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    power_next  = bad_reg ? '0 : DATA_BITS'(acc_reg);
                    match_next  = !bad_reg && cmd_reg && (acc_reg == exp_reg);
                    badout_next = bad_reg;
                    ov_next     = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != ST_IDLE))
        else $error("accepted beat did not start the sequencer");

    a_operand_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (x_reg < m_reg && p_reg < m_reg))
        else $error("product operand not reduced below modulus");

    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXP_BIT) |-> (acc_reg < m_reg && sq_reg < m_reg))
        else $error("running power not reduced below modulus");

    a_bad_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_modulus) |-> (power == '0 && !match))
        else $error("bad modulus result carries data");
`endif

endmodule
